FILE: hw/rtl/mdss_pkg.sv
// Shared types, codes and default sizes for the minimum dominating set search block.
package mdss_pkg;

    // Default sizes
    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;

    // Fixed field widths of the stream beats
    localparam int VERTEX_W   = 4;
    localparam int ROW_W      = 16;
    localparam int WEIGHT_W   = 16;
    localparam int SET_W      = 16;
    localparam int COUNT_W    = 5;
    localparam int TOTAL_W    = 20;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 48;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CHECK  = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_PREP,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/min_dominating_set_search.sv
// Top level: graph store, search sequencer and result register of the dominating set search.
// Operation: a load beat writes the graph store; a check beat passes through CHECK; a search
//   beat passes through SCAN, PREP, RUN and DONE, RUN taking one subset per cycle through
//   the shared cover test and running-sum adder. s_tready is low while a beat is in work.
// Throughput: one beat at a time; the result register frees the input side once written.
// Reset: synchronous, active low; clears sequencer, presence bits, use_weights and m_tvalid.
module min_dominating_set_search
#(
    parameter int MAX_VERTICES = mdss_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = mdss_pkg::WEIGHT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel: use_weights
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] vertex, [4] present, [20:5] neighbours, [36:21] weight, [52:37] candidate
    input  logic [mdss_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]                     s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] dominating, [16:1] best_set, [21:17] best_count, [41:22] best_weight
    output logic [mdss_pkg::M_TDATA_W-1:0] m_tdata
);

    import mdss_pkg::*;

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int SW  = WEIGHT_BITS + CW;

    // Input field unpacking
    logic [VERTEX_W-1:0] in_vertex;
    logic                in_present;
    logic [ROW_W-1:0]    in_row;
    logic [WEIGHT_W-1:0] in_weight;
    logic [SET_W-1:0]    in_cand;
    op_t                 in_op;

    assign in_vertex  = s_tdata[3:0];
    assign in_present = s_tdata[4];
    assign in_row     = s_tdata[20:5];
    assign in_weight  = s_tdata[36:21];
    assign in_cand    = s_tdata[52:37];
    assign in_op      = op_t'(s_tuser);

    // Width fitting of the fixed-width fields
    logic [VIW+VERTEX_W-1:0]       vx_wide;
    logic [MAX_VERTICES+ROW_W-1:0] row_wide;
    logic [MAX_VERTICES+SET_W-1:0] cand_wide;
    logic [WEIGHT_BITS+WEIGHT_W-1:0] wt_wide;
    logic [VIW-1:0]                vx_idx;
    logic                          vx_ok;

    assign vx_wide   = {{VIW{1'b0}}, in_vertex};
    assign row_wide  = {{MAX_VERTICES{1'b0}}, in_row};
    assign cand_wide = {{MAX_VERTICES{1'b0}}, in_cand};
    assign wt_wide   = {{WEIGHT_BITS{1'b0}}, in_weight};
    assign vx_idx    = vx_wide[VIW-1:0];
    assign vx_ok     = (int'(in_vertex) < MAX_VERTICES);

    // Registers
    state_t                  state_reg, state_next;
    logic                    use_weights_reg;
    logic [MAX_VERTICES-1:0] present_reg;
    logic [MAX_VERTICES-1:0] rows_reg    [MAX_VERTICES];
    logic [WEIGHT_BITS-1:0]  weights_reg [MAX_VERTICES];
    logic [VIW-1:0]          ordr_reg    [MAX_VERTICES];
    logic [SW-1:0]           delta_reg   [MAX_VERTICES];
    logic [VIW-1:0]          scan_idx_reg;
    logic [SW-1:0]           acc_reg;
    logic [CW-1:0]           k_reg;
    logic [MAX_VERTICES-1:0] code_reg, lim_reg, mask_reg, cand_reg;
    logic [SW-1:0]           sum_reg;
    logic [CW-1:0]           cnt_reg;
    logic [MAX_VERTICES-1:0] best_mask_reg;
    logic [SW-1:0]           best_sum_reg;
    logic [CW-1:0]           best_cnt_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic                    out_dom_reg;
    logic [SET_W-1:0]        out_set_reg;
    logic [COUNT_W-1:0]      out_cnt_reg;
    logic [TOTAL_W-1:0]      out_wt_reg;

    // Handshakes
    logic in_beat, out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && in_op == OP_CHECK) begin
                    state_next = ST_CHECK;
                end else if (in_beat && in_op == OP_SEARCH) begin
                    state_next = ST_SCAN;
                end
            end
            ST_CHECK: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_idx_reg == '0) state_next = ST_PREP;
            end
            ST_PREP: state_next = ST_RUN;
            ST_RUN: begin
                if (code_reg == lim_reg) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer strobes
    logic load_en, start_en, scan_en, prep_en, run_en, chk_wr, srch_wr;

    always_comb begin
        load_en  = 1'b0;
        start_en = 1'b0;
        scan_en  = 1'b0;
        prep_en  = 1'b0;
        run_en   = 1'b0;
        chk_wr   = 1'b0;
        srch_wr  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                load_en  = in_beat && (in_op == OP_LOAD) && vx_ok;
                start_en = in_beat && (in_op == OP_SEARCH);
            end
            ST_CHECK: chk_wr  = out_free;
            ST_SCAN:  scan_en = 1'b1;
            ST_PREP:  prep_en = 1'b1;
            ST_RUN:   run_en  = 1'b1;
            ST_DONE:  srch_wr = out_free;
            default: ;
        endcase
    end

    // Shared cover test: check candidate or current subset
    logic [MAX_VERTICES-1:0] test_mask;
    logic                    covered;

    assign test_mask = (state_reg == ST_CHECK) ? cand_reg : mask_reg;

    mdss_cover #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_cover (
        .mask    (test_mask),
        .present (present_reg),
        .rows    (rows_reg),
        .covered (covered)
    );

    // Scan step: collect present vertices from the top down, build step deltas
    logic [VIW-1:0]         scan_v;
    logic [WEIGHT_BITS-1:0] scan_w;
    logic [SW-1:0]          scan_w_ext;
    logic [VIW-1:0]         k_idx;

    assign scan_v     = scan_idx_reg;
    assign scan_w     = weights_reg[scan_v];
    assign scan_w_ext = {{CW{1'b0}}, scan_w};
    assign k_idx      = k_reg[VIW-1:0];

    // Search limit: k low bits set
    logic [MAX_VERTICES:0] lim_wide;
    assign lim_wide = ({{MAX_VERTICES{1'b0}}, 1'b1} << k_reg) - 1'b1;

    // Subset step: trailing ones of the code pick the vertex that enters
    logic [VIW-1:0]          trail;
    logic [VIW-1:0]          enter_v;
    logic [MAX_VERTICES-1:0] keep_low, enter_bit;
    logic [MAX_VERTICES-1:0] mask_next;
    logic [SW-1:0]           sum_next;
    logic [CW-1:0]           cnt_next;
    logic [VIW+CW-1:0]       trail_wide;
    logic                    better;

    always_comb begin
        trail = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (!code_reg[i]) trail = VIW'(i);
        end
    end

    assign enter_v = ordr_reg[trail];

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            keep_low[i]  = (i < int'(enter_v));
            enter_bit[i] = (i == int'(enter_v));
        end
    end

    assign trail_wide = {{CW{1'b0}}, trail};
    assign mask_next  = (mask_reg & keep_low) | enter_bit;
    assign sum_next   = sum_reg + delta_reg[trail];
    assign cnt_next   = cnt_reg + CW'(1) - trail_wide[CW-1:0];
    assign better     = use_weights_reg ? (sum_reg < best_sum_reg) : (cnt_reg < best_cnt_reg);

    // Result fitting to the output field widths
    logic [MAX_VERTICES+SET_W-1:0] set_wide;
    logic [CW+COUNT_W-1:0]         cnt_wide;
    logic [SW+TOTAL_W-1:0]         wt_out_wide;

    assign set_wide    = {{SET_W{1'b0}}, best_mask_reg};
    assign cnt_wide    = {{COUNT_W{1'b0}}, best_cnt_reg};
    assign wt_out_wide = {{TOTAL_W{1'b0}}, best_sum_reg};

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (chk_wr || srch_wr) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            use_weights_reg <= 1'b0;
            present_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) use_weights_reg <= cfg_data;
            if (load_en) present_reg[vx_idx] <= in_present;
        end
    end

    // Graph store
    always_ff @(posedge aclk) begin
        if (load_en) begin
            rows_reg[vx_idx]    <= row_wide[MAX_VERTICES-1:0];
            weights_reg[vx_idx] <= wt_wide[WEIGHT_BITS-1:0];
        end
    end

    // Check candidate capture
    always_ff @(posedge aclk) begin
        if (in_beat && in_op == OP_CHECK) cand_reg <= cand_wide[MAX_VERTICES-1:0];
    end

    // Search datapath
    always_ff @(posedge aclk) begin
        if (start_en) begin
            scan_idx_reg <= VIW'(MAX_VERTICES - 1);
            acc_reg      <= '0;
            k_reg        <= '0;
        end
        if (scan_en) begin
            scan_idx_reg <= scan_idx_reg - 1'b1;
            if (present_reg[scan_v]) begin
                ordr_reg[k_idx]  <= scan_v;
                delta_reg[k_idx] <= scan_w_ext - acc_reg;
                acc_reg          <= acc_reg + scan_w_ext;
                k_reg            <= k_reg + 1'b1;
            end
        end
        if (prep_en) begin
            best_mask_reg <= present_reg;
            best_cnt_reg  <= k_reg;
            best_sum_reg  <= acc_reg;
            lim_reg       <= lim_wide[MAX_VERTICES-1:0];
            code_reg      <= '0;
            mask_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end
        if (run_en) begin
            if (code_reg != '0 && better && covered) begin
                best_mask_reg <= mask_reg;
                best_sum_reg  <= sum_reg;
                best_cnt_reg  <= cnt_reg;
            end
            if (code_reg != lim_reg) begin
                code_reg <= code_reg + 1'b1;
                mask_reg <= mask_next;
                sum_reg  <= sum_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (chk_wr) begin
            out_dom_reg <= covered;
            out_set_reg <= '0;
            out_cnt_reg <= '0;
            out_wt_reg  <= '0;
        end else if (srch_wr) begin
            out_dom_reg <= (best_mask_reg != '0);
            out_set_reg <= set_wide[SET_W-1:0];
            out_cnt_reg <= cnt_wide[COUNT_W-1:0];
            out_wt_reg  <= wt_out_wide[TOTAL_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_wt_reg, out_cnt_reg, out_set_reg, out_dom_reg};

endmodule

FILE: hw/rtl/mdss_cover.sv
// Domination test: every present vertex is in the mask or has a present mask neighbor.
module mdss_cover #(
    parameter int MAX_VERTICES = mdss_pkg::MAX_VERTICES_DEF
) (
    input  logic [MAX_VERTICES-1:0] mask,
    input  logic [MAX_VERTICES-1:0] present,
    input  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES],
    output logic                    covered
);

    logic [MAX_VERTICES-1:0] miss;

    // One miss flag per vertex, all in parallel
    always_comb begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
            miss[v] = present[v] && !mask[v] && ((rows[v] & mask & present) == '0);
        end
    end

    // Empty mask never dominates
    assign covered = (mask != '0) && (miss == '0);

endmodule
